[hdl/ild_pkg.sv]
// shared types, constants and codes for the interrupt level demux
`timescale 1ns / 1ps

package ild_pkg;

    localparam int NUM_LINES_DEF  = 128;
    localparam int BANK_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int KIND_W        = 3;
    localparam int LINE_W        = 7;
    localparam int VALUE_W       = 4;
    localparam int LEVEL_W       = 4;
    localparam int PRIO_W        = 4;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 8;

    localparam logic [PRIO_W-1:0] TOP_PRIORITY   = 4'd14;
    localparam logic [PRIO_W-1:0] RESET_PRIORITY = 4'd7;

    // item kinds as they arrive on tuser
    localparam logic [KIND_W-1:0] KIND_LEVEL  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ENABLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PRIO   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEMUX  = 3'd5;

    typedef enum logic [2:0] {
        OP_LEVEL,
        OP_ENABLE,
        OP_PRIO,
        OP_POL,
        OP_CLEAR,
        OP_DEMUX
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [LINE_W-1:0]  line;
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  want;
        logic               search;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } back_state_t;

endpackage

[hdl/interrupt_level_demux.sv]
// top level of the interrupt level demux
// Usage:
//   Items come in on the s_axis group: tuser carries the kind (level report,
//   enable, priority or polarity write, status clear, demux), tdata the line,
//   value and cpu level. Results leave on the m_axis group, one per bank that
//   yields a line for a demux, or one spurious result; tlast marks the final
//   result of each demux, tuser[0] is set when a line was dispatched.
//   The front end decodes items into a two-entry command queue, so the input
//   keeps moving while the back end scans. Items with an out-of-range line
//   or an unknown kind are taken and dropped.
//   A write, clear or level item is done in idle with one row write. A demux
//   starts in idle, then scans one bank row a cycle (NUM_BANKS = 4 by default)
//   through the shared row read and priority encoder, waiting while a new hit
//   cannot push out the held line, and then issues the final result; the scan
//   is skipped when cpu_level is above the top priority.
//   Reset clears all pending, enable and polarity bits, sets every priority
//   to seven and empties the queue and the result register.
//   When the receiver stalls, the result register holds its item and the
//   scan waits at the next hit; the queue then fills and tready drops.
`timescale 1ns / 1ps

module interrupt_level_demux
    import ild_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int BANK_WIDTH = BANK_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // line[6:0], value[10:7], cpu_level[14:11], pad
    input  logic [KIND_W-1:0]      s_axis_tuser,  // kind[2:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // dispatched_line[6:0], pad
    output logic [0:0]             m_axis_tuser,  // found[0]
    output logic                   m_axis_tlast
);

    cmd_t              front_cmd;
    cmd_t              queue_cmd;
    logic              front_push;
    logic              queue_full;
    logic              queue_empty;
    logic              back_pop;
    logic [LINE_W-1:0] res_line;

    ild_front #(
        .NUM_LINES (NUM_LINES)
    ) u_front (
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .kind      (s_axis_tuser),
        .line      (s_axis_tdata[LINE_W-1:0]),
        .value     (s_axis_tdata[LINE_W+VALUE_W-1:LINE_W]),
        .cpu_level (s_axis_tdata[LINE_W+VALUE_W+LEVEL_W-1:LINE_W+VALUE_W]),
        .q_full    (queue_full),
        .push      (front_push),
        .cmd       (front_cmd)
    );

    ild_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .cmd_in  (front_cmd),
        .full    (queue_full),
        .pop     (back_pop),
        .empty   (queue_empty),
        .cmd_out (queue_cmd)
    );

    ild_back #(
        .NUM_LINES  (NUM_LINES),
        .BANK_WIDTH (BANK_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (queue_empty),
        .q_cmd     (queue_cmd),
        .pop       (back_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_line  (res_line),
        .out_found (m_axis_tuser[0]),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - LINE_W){1'b0}}, res_line};

endmodule

[hdl/ild_front.sv]
// front end: accepts items, drops the ones with no effect and decodes the rest
`timescale 1ns / 1ps

module ild_front
    import ild_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF
)
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [LINE_W-1:0]  line,
    input  logic [VALUE_W-1:0] value,
    input  logic [LEVEL_W-1:0] cpu_level,
    input  logic               q_full,
    output logic               push,
    output cmd_t               cmd
);

    logic keep;
    logic in_range;

    assign in_range = int'(line) < NUM_LINES;
    assign in_ready = !q_full;

    always_comb
    begin
        keep       = 1'b0;
        cmd.op     = OP_DEMUX;
        cmd.line   = line;
        cmd.value  = value;
        cmd.want   = TOP_PRIORITY - cpu_level;
        cmd.search = (cpu_level <= TOP_PRIORITY);
        unique case (kind)
            KIND_LEVEL:
            begin
                keep   = in_range;
                cmd.op = OP_LEVEL;
            end
            KIND_ENABLE:
            begin
                keep   = in_range;
                cmd.op = OP_ENABLE;
            end
            KIND_PRIO:
            begin
                keep   = in_range;
                cmd.op = OP_PRIO;
            end
            KIND_POL:
            begin
                keep   = in_range;
                cmd.op = OP_POL;
            end
            KIND_CLEAR:
            begin
                keep   = in_range;
                cmd.op = OP_CLEAR;
            end
            KIND_DEMUX:
            begin
                keep   = 1'b1;
                cmd.op = OP_DEMUX;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // dropped items are still taken off the bus
    assign push = in_valid && in_ready && keep;

endmodule

[hdl/ild_queue.sv]
// short command queue between front and back end
`timescale 1ns / 1ps

module ild_queue
    import ild_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t cmd_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[hdl/ild_back.sv]
// back end: per-line settings, bank scan and result register
`timescale 1ns / 1ps

module ild_back
    import ild_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int BANK_WIDTH = BANK_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  cmd_t                   q_cmd,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LINE_W-1:0]      out_line,
    output logic                   out_found,
    output logic                   out_last
);

    localparam int NUM_BANKS = (NUM_LINES + BANK_WIDTH - 1) / BANK_WIDTH;
    localparam int BANK_W    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int OFF_W     = $clog2(BANK_WIDTH);
    localparam int LUT_DEPTH = 1 << LINE_W;

    // settings held one bank row per entry
    logic [BANK_WIDTH-1:0]             pend_reg [NUM_BANKS];
    logic [BANK_WIDTH-1:0]             en_reg   [NUM_BANKS];
    logic [BANK_WIDTH-1:0]             pol_reg  [NUM_BANKS];
    logic [BANK_WIDTH-1:0][PRIO_W-1:0] prio_reg [NUM_BANKS];

    logic [BANK_WIDTH-1:0]             pend_row, pend_row_next;
    logic [BANK_WIDTH-1:0]             en_row,   en_row_next;
    logic [BANK_WIDTH-1:0]             pol_row,  pol_row_next;
    logic [BANK_WIDTH-1:0][PRIO_W-1:0] prio_row, prio_row_next;
    logic                              row_we;
    logic [BANK_W-1:0]                 row_sel;

    logic [BANK_W-1:0] bank_lut [LUT_DEPTH];
    logic [OFF_W-1:0]  off_lut  [LUT_DEPTH];
    logic [LINE_W-1:0] base_lut [NUM_BANKS];

    back_state_t       state_reg, state_next;
    logic [BANK_W-1:0] scan_bank_reg, scan_bank_next;
    logic [PRIO_W-1:0] want_reg, want_next;
    logic              held_valid_reg, held_valid_next;
    logic [LINE_W-1:0] held_line_reg, held_line_next;

    logic              out_valid_reg, out_valid_next;
    logic [LINE_W-1:0] out_line_reg, out_line_next;
    logic              out_found_reg, out_found_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;
    logic              slot_free;

    logic [BANK_W-1:0]     cmd_bank;
    logic [OFF_W-1:0]      cmd_off;
    logic [BANK_WIDTH-1:0] hit_vec;
    logic                  hit_any;
    logic [OFF_W-1:0]      hit_off;
    logic [LINE_W-1:0]     hit_line;

    // line to bank and offset, worked out at elaboration
    for (genvar i = 0; i < LUT_DEPTH; i++)
    begin : g_line_lut
        assign bank_lut[i] = BANK_W'(i / BANK_WIDTH);
        assign off_lut[i]  = OFF_W'(i % BANK_WIDTH);
    end

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_base_lut
        assign base_lut[b] = LINE_W'(b * BANK_WIDTH);
    end

    assign cmd_bank = bank_lut[q_cmd.line];
    assign cmd_off  = off_lut[q_cmd.line];
    assign row_sel  = (state_reg == ST_SCAN) ? scan_bank_reg : cmd_bank;

    assign pend_row = pend_reg[row_sel];
    assign en_row   = en_reg[row_sel];
    assign pol_row  = pol_reg[row_sel];
    assign prio_row = prio_reg[row_sel];

    always_comb
    begin
        for (int k = 0; k < BANK_WIDTH; k++)
        begin
            hit_vec[k] = pend_row[k] && en_row[k] && (prio_row[k] == want_reg);
        end
    end

    // lowest matching line in the row
    always_comb
    begin
        hit_off = '0;
        for (int k = BANK_WIDTH - 1; k >= 0; k--)
        begin
            if (hit_vec[k])
            begin
                hit_off = OFF_W'(k);
            end
        end
    end

    assign hit_any   = |hit_vec;
    assign hit_line  = base_lut[scan_bank_reg] + LINE_W'(hit_off);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        scan_bank_next  = scan_bank_reg;
        want_next       = want_reg;
        held_valid_next = held_valid_reg;
        held_line_next  = held_line_reg;
        pend_row_next   = pend_row;
        en_row_next     = en_row;
        pol_row_next    = pol_row;
        prio_row_next   = prio_row;
        row_we          = 1'b0;
        pop             = 1'b0;
        out_load        = 1'b0;
        out_line_next   = out_line_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop    = 1'b1;
                    row_we = (q_cmd.op != OP_DEMUX);
                    unique case (q_cmd.op)
                        OP_LEVEL:
                        begin
                            if (q_cmd.value[0] != pol_row[cmd_off])
                            begin
                                pend_row_next[cmd_off] = 1'b1;
                            end
                        end
                        OP_ENABLE:
                        begin
                            en_row_next[cmd_off] = q_cmd.value[0];
                        end
                        OP_PRIO:
                        begin
                            prio_row_next[cmd_off] = q_cmd.value;
                        end
                        OP_POL:
                        begin
                            pol_row_next[cmd_off] = q_cmd.value[0];
                        end
                        OP_CLEAR:
                        begin
                            pend_row_next[cmd_off] = 1'b0;
                        end
                        OP_DEMUX:
                        begin
                            held_valid_next = 1'b0;
                            scan_bank_next  = '0;
                            want_next       = q_cmd.want;
                            state_next      = q_cmd.search ? ST_SCAN : ST_FLUSH;
                        end
                        default:
                        begin
                            row_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // a new hit pushes the previous one out, not yet known to be final
                if (!hit_any || !held_valid_reg || slot_free)
                begin
                    if (hit_any)
                    begin
                        row_we                 = 1'b1;
                        pend_row_next[hit_off] = 1'b0;
                        held_valid_next        = 1'b1;
                        held_line_next         = hit_line;
                        if (held_valid_reg)
                        begin
                            out_load       = 1'b1;
                            out_line_next  = held_line_reg;
                            out_found_next = 1'b1;
                            out_last_next  = 1'b0;
                        end
                    end
                    if (scan_bank_reg == BANK_W'(NUM_BANKS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        scan_bank_next = scan_bank_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_line_next   = held_valid_reg ? held_line_reg : '0;
                    out_found_next  = held_valid_reg;
                    out_last_next   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_bank_reg  <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                pend_reg[b] <= '0;
                en_reg[b]   <= '0;
                pol_reg[b]  <= '0;
                prio_reg[b] <= {BANK_WIDTH{RESET_PRIORITY}};
            end
        end
        else
        begin
            state_reg      <= state_next;
            scan_bank_reg  <= scan_bank_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            if (row_we)
            begin
                pend_reg[row_sel] <= pend_row_next;
                en_reg[row_sel]   <= en_row_next;
                pol_reg[row_sel]  <= pol_row_next;
                prio_reg[row_sel] <= prio_row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg      <= want_next;
        held_line_reg <= held_line_next;
        if (out_load)
        begin
            out_line_reg  <= out_line_next;
            out_found_reg <= out_found_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_line  = out_line_reg;
    assign out_found = out_found_reg;
    assign out_last  = out_last_reg;

    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !held_valid_reg)
        else $error("held result left over outside a demux");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result register overwritten while occupied");

    a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> int'(scan_bank_reg) < NUM_BANKS)
        else $error("scan bank out of range");

    a_spurious_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_last_reg)
        else $error("spurious result not marked final");

endmodule
